// File: rtl/core/stress_divergence_face_accumulator_defines.svh
// ---------------------------------------------------------------------------
// Stress divergence face accumulator: assertion macros
// Shared concurrent assertion forms, clocked on clk, held off in reset.
// ---------------------------------------------------------------------------
`ifndef STRESS_DIVERGENCE_FACE_ACCUMULATOR_DEFINES_SVH
`define STRESS_DIVERGENCE_FACE_ACCUMULATOR_DEFINES_SVH

// same-cycle implication
`define SDFA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdfa assertion failed");

// next-cycle implication
`define SDFA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdfa assertion failed");

`endif

// File: rtl/core/sdfa_pkg.sv
// ---------------------------------------------------------------------------
// sdfa_pkg
// Types, codes and arithmetic helpers of the stress divergence accumulator.
// ---------------------------------------------------------------------------
package sdfa_pkg;

    localparam int COLLOID_SLOTS = 64;
    localparam int SLOT_W        = 6;
    localparam int STRESS_W      = 32;
    localparam int ACC_W         = 48;
    localparam int DELTA_W       = 34;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    localparam logic [1:0] FUNC_FACE         = 2'd0;
    localparam logic [1:0] FUNC_READ_COLLOID = 2'd1;
    localparam logic [1:0] FUNC_READ_WALL    = 2'd2;

    localparam logic [1:0] KIND_FLUID   = 2'd0;
    localparam logic [1:0] KIND_COLLOID = 2'd1;
    localparam logic [1:0] KIND_WALL    = 2'd2;

    localparam logic [1:0] RES_SITE    = 2'd0;
    localparam logic [1:0] RES_COLLOID = 2'd1;
    localparam logic [1:0] RES_WALL    = 2'd2;

    localparam logic REG_ANCHORING_MODE = 1'b0;

    typedef logic [2:0][ACC_W-1:0]   vec3_t;
    typedef logic [2:0][DELTA_W-1:0] delta3_t;

    typedef struct packed {
        logic [1:0]                  func;
        logic signed [STRESS_W-1:0]  own_sx;
        logic signed [STRESS_W-1:0]  own_sy;
        logic signed [STRESS_W-1:0]  own_sz;
        logic signed [STRESS_W-1:0]  nbr_sx;
        logic signed [STRESS_W-1:0]  nbr_sy;
        logic signed [STRESS_W-1:0]  nbr_sz;
        logic [1:0]                  nbr_kind;
        logic                        minus_face;
        logic [SLOT_W-1:0]           colloid_slot;
        logic                        last_face;
    } face_in_t;

    typedef struct packed {
        logic [1:0]               result_kind;
        logic signed [ACC_W-1:0]  force_x;
        logic signed [ACC_W-1:0]  force_y;
        logic signed [ACC_W-1:0]  force_z;
    } force_out_t;

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0]   acc,
        input logic signed [DELTA_W-1:0] delta
    );
        logic signed [ACC_W:0] sum;
        sum = {acc[ACC_W-1], acc} + {{(ACC_W+1-DELTA_W){delta[DELTA_W-1]}}, delta};
        if (sum[ACC_W] != sum[ACC_W-1])
        begin
            return sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return sum[ACC_W-1:0];
    endfunction

endpackage

// File: rtl/core/sdfa_apb_regs.sv
// ---------------------------------------------------------------------------
// sdfa_apb_regs
// APB register file holding the anchoring mode.
// ---------------------------------------------------------------------------
module sdfa_apb_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sdfa_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [sdfa_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [sdfa_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output logic                              anchoring_mode
);
    import sdfa_pkg::*;

    logic mode_reg;
    logic hit;

    assign pready = 1'b1;
    assign hit    = (paddr[APB_ADDR_W-1] == REG_ANCHORING_MODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && hit)
        begin
            mode_reg <= pwdata[0];
        end
    end

    assign prdata         = hit ? {{(APB_DATA_W-1){1'b0}}, mode_reg} : '0;
    assign anchoring_mode = mode_reg;

endmodule

// File: rtl/core/sdfa_colloid_ram.sv
// ---------------------------------------------------------------------------
// sdfa_colloid_ram
// Colloid force table: synchronous RAM, per-slot valid bits, write forwarding.
// ---------------------------------------------------------------------------
module sdfa_colloid_ram (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rd_en,
    input  logic [sdfa_pkg::SLOT_W-1:0]   rd_slot,
    input  logic [sdfa_pkg::SLOT_W-1:0]   s1_slot,
    input  logic                          wr_en,
    input  logic [sdfa_pkg::SLOT_W-1:0]   wr_slot,
    input  sdfa_pkg::vec3_t               wr_data,
    output sdfa_pkg::vec3_t               rd_data
);
    import sdfa_pkg::*;

    vec3_t                     mem [COLLOID_SLOTS];
    vec3_t                     rd_q_reg;
    logic [COLLOID_SLOTS-1:0]  valid_reg;
    logic                      wb_valid_reg;
    logic [SLOT_W-1:0]         wb_slot_reg;
    vec3_t                     wb_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_slot] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[rd_slot];
        end
        if (wr_en)
        begin
            wb_slot_reg <= wr_slot;
            wb_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            wb_valid_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_slot] <= 1'b1;
            wb_valid_reg       <= 1'b1;
        end
    end

    // last write always wins over the registered read
    always_comb
    begin
        if (wb_valid_reg && (wb_slot_reg == s1_slot))
        begin
            rd_data = wb_data_reg;
        end
        else if (valid_reg[s1_slot])
        begin
            rd_data = rd_q_reg;
        end
        else
        begin
            rd_data = '0;
        end
    end

endmodule

// File: rtl/core/stress_divergence_face_accumulator.sv
// ---------------------------------------------------------------------------
// stress_divergence_face_accumulator
// Pipeline: share calc is registered in stage 1, then the update in the output
//   register. Throughput: one beat per cycle while no waiting result stalls stage 1;
//   back-to-back colloid RAM read-modify-write updates of one slot are forwarded.
// Reset: clears site, wall and mode registers and all colloid valid bits,
//   so the table reads as zero at once.
// ---------------------------------------------------------------------------
module stress_divergence_face_accumulator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  sdfa_pkg::face_in_t                req,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output sdfa_pkg::force_out_t              rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sdfa_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [sdfa_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [sdfa_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import sdfa_pkg::*;
`include "stress_divergence_face_accumulator_defines.svh"

    typedef struct packed {
        logic [1:0]        func;
        logic [SLOT_W-1:0] slot;
        logic              slot_ok;
        logic              last;
        logic              col_upd;
        logic              wall_upd;
        delta3_t           delta;
    } s1_t;

    logic                        anchoring_mode;
    logic                        accept;
    logic [1:0]                  kind_eff;
    logic                        one_sided;
    logic                        slot_ok;
    delta3_t                     delta;
    logic signed [STRESS_W-1:0]  own_v [3];
    logic signed [STRESS_W-1:0]  nbr_v [3];

    logic   s1_valid_reg;
    s1_t    s1_reg;
    logic   s1_has_res;
    logic   s1_fire;
    vec3_t  site_acc_reg;
    vec3_t  wall_acc_reg;
    vec3_t  site_new;
    vec3_t  wall_new;
    vec3_t  col_old;
    vec3_t  col_new;
    vec3_t  col_wr_data;
    logic   col_wr_en;
    vec3_t  res_vec;
    logic [1:0] res_kind;

    logic        rsp_valid_reg;
    force_out_t  rsp_reg;

    sdfa_apb_regs u_regs (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .anchoring_mode (anchoring_mode)
    );

    // stage 0: face share
    assign accept = req_valid && req_ready;
    assign own_v  = '{req.own_sx, req.own_sy, req.own_sz};
    assign nbr_v  = '{req.nbr_sx, req.nbr_sy, req.nbr_sz};

    always_comb
    begin
        logic signed [STRESS_W:0]  share;
        logic signed [DELTA_W-1:0] share_x;
        if ((req.nbr_kind == KIND_COLLOID) || (req.nbr_kind == KIND_WALL))
        begin
            kind_eff = req.nbr_kind;
        end
        else
        begin
            kind_eff = KIND_FLUID;
        end
        one_sided = anchoring_mode && (kind_eff != KIND_FLUID);
        slot_ok   = (int'(req.colloid_slot) < COLLOID_SLOTS);
        for (int i = 0; i < 3; i++)
        begin
            if (one_sided)
            begin
                share = {own_v[i], 1'b0};
            end
            else
            begin
                share = {own_v[i][STRESS_W-1], own_v[i]} + {nbr_v[i][STRESS_W-1], nbr_v[i]};
            end
            share_x  = {share[STRESS_W], share};
            delta[i] = req.minus_face ? share_x : -share_x;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg.func     <= req.func;
            s1_reg.slot     <= req.colloid_slot;
            s1_reg.slot_ok  <= slot_ok;
            s1_reg.last     <= req.last_face;
            s1_reg.col_upd  <= (kind_eff == KIND_COLLOID) && slot_ok;
            s1_reg.wall_upd <= (kind_eff == KIND_WALL) && anchoring_mode;
            s1_reg.delta    <= delta;
        end
    end

    sdfa_colloid_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_slot (req.colloid_slot),
        .s1_slot (s1_reg.slot),
        .wr_en   (col_wr_en),
        .wr_slot (s1_reg.slot),
        .wr_data (col_wr_data),
        .rd_data (col_old)
    );

    // stage 1: accumulate
    assign s1_has_res = s1_valid_reg &&
        ((s1_reg.func == FUNC_READ_COLLOID) || (s1_reg.func == FUNC_READ_WALL) ||
         ((s1_reg.func == FUNC_FACE) && s1_reg.last));
    assign s1_fire    = s1_valid_reg && (!s1_has_res || !rsp_valid_reg || rsp_ready);
    assign req_ready  = !s1_valid_reg || s1_fire;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            site_new[i] = sat_add(site_acc_reg[i], s1_reg.delta[i]);
            wall_new[i] = sat_add(wall_acc_reg[i], -s1_reg.delta[i]);
            col_new[i]  = sat_add(col_old[i], -s1_reg.delta[i]);
        end
    end

    always_comb
    begin
        col_wr_en   = 1'b0;
        col_wr_data = col_new;
        res_vec     = site_new;
        res_kind    = RES_SITE;
        unique case (s1_reg.func)
            FUNC_FACE:
            begin
                col_wr_en = s1_fire && s1_reg.col_upd;
            end
            FUNC_READ_COLLOID:
            begin
                col_wr_en   = s1_fire && s1_reg.slot_ok;
                col_wr_data = '0;
                res_vec     = s1_reg.slot_ok ? col_old : '0;
                res_kind    = RES_COLLOID;
            end
            FUNC_READ_WALL:
            begin
                res_vec  = wall_acc_reg;
                res_kind = RES_WALL;
            end
            default:
            begin
                col_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            site_acc_reg <= '0;
            wall_acc_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire && (s1_reg.func == FUNC_FACE))
            begin
                site_acc_reg <= s1_reg.last ? '0 : site_new;
                if (s1_reg.wall_upd)
                begin
                    wall_acc_reg <= wall_new;
                end
            end
            else if (s1_fire && (s1_reg.func == FUNC_READ_WALL))
            begin
                wall_acc_reg <= '0;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_has_res)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_has_res)
        begin
            rsp_reg.result_kind <= res_kind;
            rsp_reg.force_x     <= res_vec[0];
            rsp_reg.force_y     <= res_vec[1];
            rsp_reg.force_z     <= res_vec[2];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `SDFA_ASSERT_IMP(a_stall_cause, !req_ready, s1_valid_reg && rsp_valid_reg && !rsp_ready)
    `SDFA_ASSERT_NEXT(a_result_shown, s1_fire && s1_has_res, rsp_valid)
    `SDFA_ASSERT_NEXT(a_site_cleared, s1_fire && (s1_reg.func == FUNC_FACE) && s1_reg.last, site_acc_reg == '0)
    `SDFA_ASSERT_NEXT(a_wall_cleared, s1_fire && (s1_reg.func == FUNC_READ_WALL), wall_acc_reg == '0)

endmodule
